// ----- rtl/trm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trm_pkg
// Shared types and constants of the tiny register machine step block.
// ----------------------------------------------------------------------------
package trm_pkg;

  localparam int unsigned RamWords = 1024;
  localparam int unsigned DataW    = 16;
  localparam int unsigned RegCount = 32;
  localparam int unsigned RegIdxW  = 5;
  localparam int unsigned LoadAddrW = 10;
  localparam int unsigned DivCntW  = 4;

  localparam logic [DataW-1:0] DivByZero = 16'h7fff;

  typedef enum logic [3:0] {
    OP_NOP  = 4'd0,
    OP_MOV  = 4'd1,
    OP_ORI  = 4'd2,
    OP_ADD  = 4'd3,
    OP_SUB  = 4'd4,
    OP_MUL  = 4'd5,
    OP_DIV  = 4'd6,
    OP_AND  = 4'd7,
    OP_OR   = 4'd8,
    OP_XOR  = 4'd9,
    OP_SHL  = 4'd10,
    OP_SHR  = 4'd11,
    OP_JZ   = 4'd12,
    OP_JNZ  = 4'd13,
    OP_JPOS = 4'd14,
    OP_JNEG = 4'd15
  } opcode_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FETCH,
    ST_RREG,
    ST_LREG,
    ST_LMEM,
    ST_DIV,
    ST_WB
  } state_e;

  typedef struct packed {
    logic accept;
    logic fetch;
    logic rd_right;
    logic rd_left;
    logic left_mem;
    logic div_step;
    logic wb;
  } cmd_t;

  typedef struct packed {
    logic div_needed;
    logic div_done;
  } sts_t;

endpackage

// ----- rtl/tiny_register_machine_step_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tiny_register_machine_step_top
// 16-bit, 32-register machine: loads program words and executes one
// instruction per execute request.
//
//   channel | direction | handshake               | payload
//   in      | in        | in_valid_i / in_stall_o  | mode, load_address, load_value
//   out     | out       | out_valid_o / out_stall_i| io_write, io_address, io_value,
//           |           |                         | instruction_pointer, executed_word
//
// A load request goes straight to writeback, an execute request steps through
// fetch and operand reads, and a divide with a nonzero divisor also through the bit-serial divider.
// Fetch, operand reads and writeback take turns on the single memory port.
// Reset clears the registers and control state; memory is undefined.
// A new request is taken only when the previous one has reached the output
// register; a stalled result holds the sequencer in writeback.
// ----------------------------------------------------------------------------
module tiny_register_machine_step_top #(
  parameter int unsigned RAM_WORDS = trm_pkg::RamWords
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          mode_i,
  input  logic [trm_pkg::LoadAddrW-1:0] load_address_i,
  input  logic [trm_pkg::DataW-1:0]     load_value_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          io_write_o,
  output logic [trm_pkg::DataW-1:0]     io_address_o,
  output logic [trm_pkg::DataW-1:0]     io_value_o,
  output logic [trm_pkg::DataW-1:0]     instruction_pointer_o,
  output logic [trm_pkg::DataW-1:0]     executed_word_o
);

  trm_pkg::cmd_t cmd;
  trm_pkg::sts_t sts;

  trm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .mode_i      (mode_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  trm_dp #(
    .RAM_WORDS (RAM_WORDS)
  ) u_dp (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cmd_i                 (cmd),
    .sts_o                 (sts),
    .mode_i                (mode_i),
    .load_address_i        (load_address_i),
    .load_value_i          (load_value_i),
    .io_write_o            (io_write_o),
    .io_address_o          (io_address_o),
    .io_value_o            (io_value_o),
    .instruction_pointer_o (instruction_pointer_o),
    .executed_word_o       (executed_word_o)
  );

endmodule

// ----- rtl/trm_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trm_ctrl
// Sequencer that steps one request through fetch, operand reads, divide and
// writeback, and owns the output valid flag.
// ----------------------------------------------------------------------------
module trm_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic          mode_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  input  trm_pkg::sts_t sts_i,
  output trm_pkg::cmd_t cmd_o
);

  trm_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= trm_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      trm_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d = mode_i ? trm_pkg::ST_FETCH : trm_pkg::ST_WB;
        end
      end
      trm_pkg::ST_FETCH: begin
        cmd_o.fetch = 1'b1;
        state_d = trm_pkg::ST_RREG;
      end
      trm_pkg::ST_RREG: begin
        cmd_o.rd_right = 1'b1;
        state_d = trm_pkg::ST_LREG;
      end
      trm_pkg::ST_LREG: begin
        cmd_o.rd_left = 1'b1;
        state_d = trm_pkg::ST_LMEM;
      end
      trm_pkg::ST_LMEM: begin
        cmd_o.left_mem = 1'b1;
        state_d = sts_i.div_needed ? trm_pkg::ST_DIV : trm_pkg::ST_WB;
      end
      trm_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_done) begin
          state_d = trm_pkg::ST_WB;
        end
      end
      trm_pkg::ST_WB: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.wb = 1'b1;
          state_d = trm_pkg::ST_IDLE;
        end
      end
      default: state_d = trm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.wb) begin
      out_valid_d = 1'b1;
    end
  end

  assign in_stall_o  = (state_q != trm_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;

  a_wb_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.wb |=> out_valid_q)
    else $error("Writeback did not raise the output valid flag.");

  a_wb_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.wb |-> !(out_valid_q && out_stall_i))
    else $error("Writeback overwrote a result that was still stalled.");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.accept |=> in_stall_o)
    else $error("Block stayed open after accepting a request.");

endmodule

// ----- rtl/trm_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trm_dp
// Datapath: register file, program memory, operand registers, iterative
// divider, result logic and the output register.
// ----------------------------------------------------------------------------
module trm_dp #(
  parameter int unsigned RAM_WORDS = trm_pkg::RamWords
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  trm_pkg::cmd_t                     cmd_i,
  output trm_pkg::sts_t                     sts_o,
  input  logic                              mode_i,
  input  logic [trm_pkg::LoadAddrW-1:0]     load_address_i,
  input  logic [trm_pkg::DataW-1:0]         load_value_i,
  output logic                              io_write_o,
  output logic [trm_pkg::DataW-1:0]         io_address_o,
  output logic [trm_pkg::DataW-1:0]         io_value_o,
  output logic [trm_pkg::DataW-1:0]         instruction_pointer_o,
  output logic [trm_pkg::DataW-1:0]         executed_word_o
);

  localparam int unsigned AddrW = $clog2(RAM_WORDS);
  localparam int unsigned DW    = trm_pkg::DataW;
  localparam logic [DW:0] RamLim = (DW+1)'(RAM_WORDS);

  logic [DW-1:0] mem [RAM_WORDS];
  logic [DW-1:0] mem_rdata_q;
  logic          mem_ok_q;
  logic [DW-1:0] mem_addr;
  logic          mem_rd, mem_wr;
  logic [DW-1:0] mem_wdata;
  logic          mem_in_range;

  logic [DW-1:0] rf [trm_pkg::RegCount];
  logic [trm_pkg::RegCount-1:0] rf_vld_q;
  logic [DW-1:0] rf_rdata_q;
  logic [trm_pkg::RegIdxW-1:0] rf_raddr;
  logic          rf_rd, rf_wr;

  logic [DW-1:0] ip_q, ip_d;
  logic          is_load_q;
  logic [trm_pkg::LoadAddrW-1:0] ld_addr_q;
  logic [DW-1:0] ld_val_q;
  logic [DW-1:0] word_q, value_q, left_addr_q, left_q;
  logic [DW-1:0] mem_data, left_fin;

  logic [DW-1:0] quo_q, rem_q;
  logic [trm_pkg::DivCntW-1:0] cnt_q;
  logic [DW:0]   div_trial;
  logic          div_ge;

  trm_pkg::opcode_e op;
  logic          lind, rind;
  logic [trm_pkg::RegIdxW-1:0] li;
  logic [DW-1:0] res;
  logic [2*DW-1:0] prod;
  logic          do_write, do_jump, left_ok, io_hit;

  logic          io_write_q;
  logic [DW-1:0] io_address_q, io_value_q, ip_out_q, word_out_q;

  assign mem_data = mem_ok_q ? mem_rdata_q : '0;
  assign op   = trm_pkg::opcode_e'(word_q[3:0]);
  assign lind = word_q[9];
  assign rind = word_q[15];
  assign li   = word_q[8:4];
  assign left_fin = lind ? mem_data : left_addr_q;
  assign left_ok  = ({1'b0, left_addr_q} < RamLim);

  always_comb begin
    mem_addr  = ip_q;
    mem_rd    = 1'b0;
    mem_wr    = 1'b0;
    mem_wdata = res;
    if (cmd_i.accept) begin
      mem_rd = mode_i;
    end else if (cmd_i.rd_right) begin
      mem_addr = rf_rdata_q;
      mem_rd   = rind;
    end else if (cmd_i.rd_left) begin
      mem_addr = rf_rdata_q;
      mem_rd   = lind;
    end else if (cmd_i.wb) begin
      if (is_load_q) begin
        mem_addr  = DW'(ld_addr_q);
        mem_wdata = ld_val_q;
        mem_wr    = 1'b1;
      end else begin
        mem_addr = left_addr_q;
        mem_wr   = do_write && lind;
      end
    end
    mem_in_range = ({1'b0, mem_addr} < RamLim);
  end

  always_ff @(posedge clk_i) begin
    if (mem_wr && mem_in_range) begin
      mem[mem_addr[AddrW-1:0]] <= mem_wdata;
    end
    if (mem_rd && mem_in_range) begin
      mem_rdata_q <= mem[mem_addr[AddrW-1:0]];
    end
    if (mem_rd) begin
      mem_ok_q <= mem_in_range;
    end
  end

  always_comb begin
    rf_raddr = word_q[14:10];
    rf_rd    = 1'b0;
    if (cmd_i.fetch) begin
      rf_raddr = mem_data[14:10];
      rf_rd    = 1'b1;
    end else if (cmd_i.rd_right) begin
      rf_raddr = li;
      rf_rd    = 1'b1;
    end
  end

  assign rf_wr = cmd_i.wb && !is_load_q && do_write && !lind && (li != '0);

  always_ff @(posedge clk_i) begin
    if (rf_rd) begin
      if (rf_raddr == '0) begin
        rf_rdata_q <= ip_q;
      end else begin
        rf_rdata_q <= rf_vld_q[rf_raddr] ? rf[rf_raddr] : '0;
      end
    end
    if (rf_wr) begin
      rf[li] <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rf_vld_q <= '0;
      ip_q     <= '0;
    end else begin
      if (rf_wr) begin
        rf_vld_q[li] <= 1'b1;
      end
      ip_q <= ip_d;
    end
  end

  assign prod = left_q * value_q;

  always_comb begin
    res      = '0;
    do_write = 1'b1;
    do_jump  = 1'b0;
    case (op)
      trm_pkg::OP_NOP:  do_write = 1'b0;
      trm_pkg::OP_MOV:  res = value_q;
      trm_pkg::OP_ORI:  res = left_q | DW'(word_q[15:10]);
      trm_pkg::OP_ADD:  res = left_q + value_q;
      trm_pkg::OP_SUB:  res = left_q - value_q;
      trm_pkg::OP_MUL:  res = prod[DW-1:0];
      trm_pkg::OP_DIV:  res = (value_q != '0) ? quo_q : trm_pkg::DivByZero;
      trm_pkg::OP_AND:  res = left_q & value_q;
      trm_pkg::OP_OR:   res = left_q | value_q;
      trm_pkg::OP_XOR:  res = left_q ^ value_q;
      trm_pkg::OP_SHL:  res = (value_q < DW'(16)) ? (left_q << value_q[3:0]) : '0;
      trm_pkg::OP_SHR:  res = (value_q < DW'(16)) ? (left_q >> value_q[3:0]) : '0;
      trm_pkg::OP_JZ: begin
        do_write = 1'b0;
        do_jump  = (left_q == '0);
      end
      trm_pkg::OP_JNZ: begin
        do_write = 1'b0;
        do_jump  = (left_q != '0);
      end
      trm_pkg::OP_JPOS: begin
        do_write = 1'b0;
        do_jump  = (left_q != '0) && !left_q[DW-1];
      end
      trm_pkg::OP_JNEG: begin
        do_write = 1'b0;
        do_jump  = left_q[DW-1];
      end
      default: do_write = 1'b0;
    endcase
  end

  assign io_hit = do_write && lind && !left_ok;

  always_comb begin
    ip_d = ip_q;
    if (cmd_i.accept && mode_i) begin
      ip_d = ip_q + DW'(1);
    end else if (cmd_i.wb && !is_load_q) begin
      if (do_jump) begin
        ip_d = value_q;
      end else if (do_write && !lind && (li == '0)) begin
        ip_d = res;
      end
    end
  end

  assign div_trial = {rem_q, quo_q[DW-1]};
  assign div_ge    = (div_trial >= {1'b0, value_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      is_load_q <= !mode_i;
      ld_addr_q <= load_address_i;
      ld_val_q  <= load_value_i;
    end
    if (cmd_i.fetch) begin
      word_q <= mem_data;
    end
    if (cmd_i.rd_right) begin
      value_q <= rf_rdata_q;
    end
    if (cmd_i.rd_left) begin
      if (rind) begin
        value_q <= mem_data;
      end
      left_addr_q <= rf_rdata_q;
    end
    if (cmd_i.left_mem) begin
      left_q <= left_fin;
      quo_q  <= left_fin;
      rem_q  <= '0;
      cnt_q  <= '0;
    end
    if (cmd_i.div_step) begin
      cnt_q <= cnt_q + 1'b1;
      if (div_ge) begin
        rem_q <= DW'(div_trial - {1'b0, value_q});
        quo_q <= {quo_q[DW-2:0], 1'b1};
      end else begin
        rem_q <= div_trial[DW-1:0];
        quo_q <= {quo_q[DW-2:0], 1'b0};
      end
    end
    if (cmd_i.wb) begin
      io_write_q   <= !is_load_q && io_hit;
      io_address_q <= (!is_load_q && io_hit) ? left_addr_q : '0;
      io_value_q   <= (!is_load_q && io_hit) ? res : '0;
      ip_out_q     <= ip_d;
      word_out_q   <= is_load_q ? '0 : word_q;
    end
  end

  assign sts_o.div_needed = (op == trm_pkg::OP_DIV) && (value_q != '0);
  assign sts_o.div_done   = (cnt_q == '1);

  assign io_write_o            = io_write_q;
  assign io_address_o          = io_address_q;
  assign io_value_o            = io_value_q;
  assign instruction_pointer_o = ip_out_q;
  assign executed_word_o       = word_out_q;

endmodule

// ----- tb/tb_tiny_register_machine_step_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tiny_register_machine_step_top
// Self-checking bench for the tiny register machine step block. A directed
// program exercises every opcode but NOP, the io path, reads beyond memory, divide by
// zero, large shifts and jumps. A random program follows, with loads issued
// ahead of any fetch or operand read of a word that was never written. A
// built-in predictor computes the result of each request as the program is
// built, and a monitor compares the results field by field under random
// idling.
// ----------------------------------------------------------------------------
module tb_tiny_register_machine_step_top;

  localparam int unsigned NumReqs  = 1250;
  localparam int unsigned MaxCycles = 1000000;

  typedef struct packed {
    logic        io;
    logic [15:0] io_addr;
    logic [15:0] io_val;
    logic [15:0] ip;
    logic [15:0] word;
  } step_res_t;

  typedef struct {
    logic      mode;
    logic [9:0] addr;
    logic [15:0] val;
    bit        drain;
    step_res_t res;
  } step_req_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        mode_i = 1'b0;
  logic [9:0]  load_address_i = '0;
  logic [15:0] load_value_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        io_write_o;
  logic [15:0] io_address_o;
  logic [15:0] io_value_o;
  logic [15:0] instruction_pointer_o;
  logic [15:0] executed_word_o;

  step_req_t   req_q[$];
  step_res_t   result_q[$];
  logic [15:0] reg_file[trm_pkg::RegCount];
  logic [15:0] ram[trm_pkg::RamWords];
  bit          ram_valid[trm_pkg::RamWords];
  bit          hold_next;
  int unsigned total_reqs;
  int unsigned sent;
  int unsigned mismatches;
  int unsigned cycles;
  int unsigned send_idle;
  int unsigned recv_idle;
  bit          go_w;

  tiny_register_machine_step_top DUT (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .in_valid_i           (in_valid_i),
    .in_stall_o           (in_stall_o),
    .mode_i               (mode_i),
    .load_address_i       (load_address_i),
    .load_value_i         (load_value_i),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .io_write_o           (io_write_o),
    .io_address_o         (io_address_o),
    .io_value_o           (io_value_o),
    .instruction_pointer_o(instruction_pointer_o),
    .executed_word_o      (executed_word_o)
  );

  function automatic logic [15:0] ram_rd(input logic [15:0] a, inout bit bad);
    if (a < trm_pkg::RamWords) begin
      if (!ram_valid[a[9:0]]) bad = 1'b1;
      return ram[a[9:0]];
    end
    return '0;
  endfunction

  function automatic logic [15:0] enc(input trm_pkg::opcode_e op, input int li,
                                      input bit lind, input int ri, input bit rind);
    return {rind, 5'(ri), lind, 5'(li), op};
  endfunction

  // Executes the instruction at the instruction pointer; state changes only on commit.
  function automatic void run_instr(input bit commit, output step_res_t r, output bit bad);
    logic [15:0] ip, nip, word, value, left, res, la;
    logic [4:0]  li, ri;
    trm_pkg::opcode_e op;
    bit          lind, wr, jmp;
    bad = 1'b0;
    ip = reg_file[0];
    nip = ip + 16'd1;
    word = ram_rd(ip, bad);
    op = trm_pkg::opcode_e'(word[3:0]);
    lind = word[9];
    li = word[8:4];
    ri = word[14:10];
    value = (ri == 0) ? nip : reg_file[ri];
    if (word[15]) value = ram_rd(value, bad);
    la = (li == 0) ? nip : reg_file[li];
    left = lind ? ram_rd(la, bad) : la;
    wr = 1'b1;
    jmp = 1'b0;
    res = '0;
    case (op)
      trm_pkg::OP_NOP:  wr = 1'b0;
      trm_pkg::OP_MOV:  res = value;
      trm_pkg::OP_ORI:  res = left | {10'd0, word[15:10]};
      trm_pkg::OP_ADD:  res = left + value;
      trm_pkg::OP_SUB:  res = left - value;
      trm_pkg::OP_MUL:  res = left * value;
      trm_pkg::OP_DIV:  res = (value != 0) ? left / value : trm_pkg::DivByZero;
      trm_pkg::OP_AND:  res = left & value;
      trm_pkg::OP_OR:   res = left | value;
      trm_pkg::OP_XOR:  res = left ^ value;
      trm_pkg::OP_SHL:  res = (value < 16) ? left << value[3:0] : '0;
      trm_pkg::OP_SHR:  res = (value < 16) ? left >> value[3:0] : '0;
      trm_pkg::OP_JZ:   begin wr = 1'b0; jmp = (left == 0); end
      trm_pkg::OP_JNZ:  begin wr = 1'b0; jmp = (left != 0); end
      trm_pkg::OP_JPOS: begin wr = 1'b0; jmp = (left != 0) && !left[15]; end
      default: begin wr = 1'b0; jmp = (left != 0) && left[15]; end
    endcase
    r = '0;
    r.word = word;
    r.ip = nip;
    if (wr) begin
      if (lind) begin
        if (la >= trm_pkg::RamWords) begin
          r.io = 1'b1;
          r.io_addr = la;
          r.io_val = res;
        end else if (commit) begin
          ram[la[9:0]] = res;
          ram_valid[la[9:0]] = 1'b1;
        end
      end else begin
        if (li == 0) r.ip = res;
        if (commit) reg_file[li] = res;
      end
    end
    if (jmp) r.ip = value;
    if (commit) reg_file[0] = r.ip;
  endfunction

  function automatic void push_req(input logic mode, input logic [9:0] a,
                                   input logic [15:0] v, input step_res_t r);
    step_req_t q;
    q.mode = mode;
    q.addr = a;
    q.val = v;
    q.drain = hold_next;
    q.res = r;
    hold_next = 1'b0;
    req_q.push_back(q);
  endfunction

  function automatic void add_load(input logic [9:0] a, input logic [15:0] v);
    step_res_t r;
    ram[a] = v;
    ram_valid[a] = 1'b1;
    r = '0;
    r.ip = reg_file[0];
    push_req(1'b0, a, v, r);
  endfunction

  function automatic void add_exec();
    step_res_t r;
    bit bad;
    run_instr(1'b1, r, bad);
    push_req(1'b1, 10'($urandom), 16'($urandom), r);
  endfunction

  function automatic void put_word(input logic [15:0] w);
    add_load(reg_file[0][9:0], w);
    add_exec();
  endfunction

  function automatic logic [15:0] rand_word();
    int li, ri;
    li = ($urandom_range(19) == 0) ? 0 : $urandom_range(1, 7);
    ri = ($urandom_range(3) == 0) ? $urandom_range(31) : $urandom_range(0, 7);
    return enc(trm_pkg::opcode_e'($urandom_range(15)), li, $urandom_range(3) == 0,
               ri, $urandom_range(3) == 0);
  endfunction

  // Loads any unwritten word that the next instruction would read, then
  // executes it once the instruction pointer stays inside memory or the tries run out.
  function automatic void add_random_step();
    step_res_t r;
    bit bad;
    bit done;
    int tries;
    logic [15:0] a;
    done = 1'b0;
    tries = 0;
    if (!ram_valid[reg_file[0][9:0]] || $urandom_range(9) < 6)
      add_load(reg_file[0][9:0], rand_word());
    while (!done) begin
      run_instr(1'b0, r, bad);
      if (bad) begin
        for (int k = 0; k < 3 && bad; k++) begin
          bad = 1'b0;
          a = reg_file[0] + 16'd1;
          void'(ram_rd(reg_file[0], bad));
          if (ram[reg_file[0][9:0]][15]) begin
            a = (ram[reg_file[0][9:0]][14:10] == 0) ? a
                : reg_file[ram[reg_file[0][9:0]][14:10]];
            if (a < trm_pkg::RamWords && !ram_valid[a[9:0]])
              add_load(a[9:0], 16'($urandom));
          end
          a = (ram[reg_file[0][9:0]][8:4] == 0) ? reg_file[0] + 16'd1
              : reg_file[ram[reg_file[0][9:0]][8:4]];
          if (ram[reg_file[0][9:0]][9] && a < trm_pkg::RamWords && !ram_valid[a[9:0]])
            add_load(a[9:0], 16'($urandom));
        end
        run_instr(1'b0, r, bad);
      end
      if (!bad && (r.ip < trm_pkg::RamWords || tries >= 8)) begin
        done = 1'b1;
      end else begin
        tries++;
        add_load(reg_file[0][9:0], rand_word());
      end
    end
    add_exec();
  endfunction

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    for (int i = 0; i < trm_pkg::RegCount; i++) reg_file[i] = '0;
    hold_next = 1'b0;
    add_load(10'd1023, 16'hffff);
    add_load(10'd0, 16'h0000);
    put_word(enc(trm_pkg::OP_ORI, 1, 0, 31, 1));
    put_word(enc(trm_pkg::OP_ORI, 2, 0, 2, 1));
    put_word(enc(trm_pkg::OP_SHL, 1, 0, 2, 0));
    put_word(enc(trm_pkg::OP_MOV, 9, 0, 1, 0));
    put_word(enc(trm_pkg::OP_ORI, 3, 0, 5, 0));
    put_word(enc(trm_pkg::OP_MOV, 6, 0, 1, 0));
    put_word(enc(trm_pkg::OP_SHL, 6, 0, 3, 0));
    put_word(enc(trm_pkg::OP_SHR, 4, 0, 2, 0));
    put_word(enc(trm_pkg::OP_DIV, 7, 0, 8, 0));
    put_word(enc(trm_pkg::OP_DIV, 1, 0, 2, 0));
    put_word(enc(trm_pkg::OP_MUL, 1, 0, 1, 0));
    put_word(enc(trm_pkg::OP_ADD, 9, 1, 2, 0));
    put_word(enc(trm_pkg::OP_SUB, 5, 0, 2, 0));
    put_word(enc(trm_pkg::OP_AND, 1, 0, 2, 0));
    put_word(enc(trm_pkg::OP_OR, 1, 0, 9, 0));
    put_word(enc(trm_pkg::OP_XOR, 1, 0, 1, 0));
    put_word(enc(trm_pkg::OP_ORI, 11, 0, 18, 1));
    add_load(10'd50, 16'h0000);
    put_word(enc(trm_pkg::OP_MOV, 11, 1, 2, 0));
    put_word(enc(trm_pkg::OP_MOV, 12, 0, 11, 1));
    put_word(enc(trm_pkg::OP_MOV, 10, 0, 9, 1));
    put_word(enc(trm_pkg::OP_ORI, 0, 0, 0, 0));
    put_word(enc(trm_pkg::OP_ORI, 14, 0, 8, 1));
    put_word(enc(trm_pkg::OP_JZ, 2, 0, 14, 0));
    put_word(enc(trm_pkg::OP_JNZ, 8, 0, 14, 0));
    put_word(enc(trm_pkg::OP_JPOS, 2, 0, 14, 0));
    put_word(enc(trm_pkg::OP_JNEG, 9, 0, 14, 0));
    put_word(enc(trm_pkg::OP_JNZ, 11, 1, 14, 0));
    put_word(enc(trm_pkg::OP_JZ, 8, 0, 14, 0));
    while (req_q.size() < NumReqs) begin
      if (req_q.size() >= NumReqs / 2 && req_q.size() < NumReqs / 2 + 3) hold_next = 1'b1;
      if ($urandom_range(9) == 0) add_load(10'($urandom), 16'($urandom));
      else add_random_step();
    end
    total_reqs = req_q.size();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (sent == total_reqs);
    wait (result_q.size() == 0);
    repeat (40) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb_tiny_register_machine_step_top passed");
    end else begin
      $display("tb_tiny_register_machine_step_top failed");
    end
    $finish;
  end

  always_comb begin
    if (sent < total_reqs / 3) begin
      send_idle = 31;
      recv_idle = 81;
    end else if (sent < 2 * total_reqs / 3) begin
      send_idle = 81;
      recv_idle = 31;
    end else begin
      send_idle = 0;
      recv_idle = 0;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      mode_i <= 1'b0;
      load_address_i <= '0;
      load_value_i <= '0;
    end else if (!(in_valid_i && in_stall_o)) begin
      if (in_valid_i) begin
        result_q.push_back(req_q[0].res);
        req_q.pop_front();
        sent++;
      end
      go_w = req_q.size() > 0 && $urandom_range(99) >= send_idle;
      if (go_w && req_q[0].drain && result_q.size() != 0) go_w = 1'b0;
      in_valid_i <= go_w;
      if (go_w) begin
        mode_i <= req_q[0].mode;
        load_address_i <= req_q[0].addr;
        load_value_i <= req_q[0].val;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (result_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected result with no request pending.");
        end else begin
          if ({io_write_o, io_address_o, io_value_o, instruction_pointer_o,
               executed_word_o} !== result_q[0]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Mismatch: expected io %0b addr %h val %h ip %h word %h, got io %0b addr %h val %h ip %h word %h.",
                       result_q[0].io, result_q[0].io_addr, result_q[0].io_val,
                       result_q[0].ip, result_q[0].word, io_write_o, io_address_o,
                       io_value_o, instruction_pointer_o, executed_word_o);
          end
          result_q.pop_front();
        end
      end
      out_stall_i <= $urandom_range(99) < recv_idle;
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles == MaxCycles) begin
      $display("tb_tiny_register_machine_step_top failed");
      $finish;
    end
  end

endmodule
